### rtl/byte_fifo_overflow_marker_defines.svh
// Assertion macros used by the byte FIFO top level.
`ifndef BYTE_FIFO_OVERFLOW_MARKER_DEFINES_SVH
`define BYTE_FIFO_OVERFLOW_MARKER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BFOM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("byte fifo assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define BFOM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("byte fifo assertion failed");

`endif

### rtl/bfom_pkg.sv
// Constants, types and helper functions of the byte FIFO with overflow marker.
package bfom_pkg;

   localparam int DEPTH      = 1024 * 16;
   localparam int PTR_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int LEVEL_W    = 15;
   localparam int DATA_W     = 8;
   localparam int MARK_LEN   = 8;
   localparam int MARK_IDX_W = $clog2(MARK_LEN);

   localparam logic [CNT_W-1:0] CNT_FULL     = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_MARK_AT  = CNT_W'(DEPTH - MARK_LEN);
   localparam logic [PTR_W-1:0] PTR_LAST     = PTR_W'(DEPTH - 1);
   localparam logic [MARK_IDX_W-1:0] MARK_IDX_LAST = MARK_IDX_W'(MARK_LEN - 1);

   // Overflow marker text: CR LF "FULL" CR LF.
   localparam logic [DATA_W-1:0] MARK_BYTES [MARK_LEN] =
      '{8'h0D, 8'h0A, 8'h46, 8'h55, 8'h4C, 8'h4C, 8'h0D, 8'h0A};

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_POP  = 3'b010,
      ST_MARK = 3'b100
   } state_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] res;
      if (ptr == PTR_LAST) begin
         res = '0;
      end else begin
         res = ptr + 1'b1;
      end
      return res;
   endfunction

endpackage

### rtl/bfom_ram.sv
// Single-port-write, single-port-read byte RAM with a registered read.
module bfom_ram #(
   parameter int ADDR_W = 14,
   parameter int DATA_W = 8,
   parameter int WORDS  = 16384
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [WORDS];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/byte_fifo_overflow_marker.sv
// Top level of the circular byte FIFO that writes an overflow marker when it fills.
//
//   channel  dir  handshake              payload
//   req      in   req_valid, req_stall   req_op, req_data
//   rsp      out  rsp_valid, rsp_stall   accepted, marker, read data/valid, level, flags
//
// A push, clear, idle or empty-pop request has its result registered at acceptance.
// A pop with data registers the byte RAM read first and then the result.
// A push that writes the marker makes one RAM write per marker byte while requests stall.
// Reset clears the state, pointers, count, marker index and rsp_valid, but not the RAM.
// A result held under rsp_stall keeps new requests stalled until it is taken.
`include "byte_fifo_overflow_marker_defines.svh"

module byte_fifo_overflow_marker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_op,
   input  logic [bfom_pkg::DATA_W-1:0] req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_accepted,
   output logic                        rsp_marker_inserted,
   output logic [bfom_pkg::DATA_W-1:0] rsp_read_data,
   output logic                        rsp_read_valid,
   output logic [bfom_pkg::LEVEL_W-1:0] rsp_level,
   output logic                        rsp_empty_res,
   output logic                        rsp_full_res
);
   import bfom_pkg::*;

   state_type             state_ff, state_in;
   logic [PTR_W-1:0]      wp_ff, wp_in;
   logic [PTR_W-1:0]      rp_ff, rp_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [MARK_IDX_W-1:0] mark_idx_ff, mark_idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_accepted_ff, rsp_accepted_in;
   logic                  rsp_marker_ff, rsp_marker_in;
   logic [DATA_W-1:0]     rsp_read_data_ff, rsp_read_data_in;
   logic                  rsp_read_valid_ff, rsp_read_valid_in;
   logic [LEVEL_W-1:0]    rsp_level_ff, rsp_level_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic                  rsp_full_ff, rsp_full_in;

   logic                  req_accept;
   logic                  wr_en;
   logic [PTR_W-1:0]      wr_addr;
   logic [DATA_W-1:0]     wr_data;
   logic                  rd_en;
   logic [DATA_W-1:0]     rd_data;

   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   bfom_ram #(
      .ADDR_W (PTR_W),
      .DATA_W (DATA_W),
      .WORDS  (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rp_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      logic [CNT_W-1:0] cnt_next;
      cnt_next          = cnt_ff;
      state_in          = state_ff;
      wp_in             = wp_ff;
      rp_in             = rp_ff;
      cnt_in            = cnt_ff;
      mark_idx_in       = mark_idx_ff;
      wr_en             = 1'b0;
      wr_addr           = wp_ff;
      wr_data           = req_data;
      rd_en             = 1'b0;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_accepted_in   = rsp_accepted_ff;
      rsp_marker_in     = rsp_marker_ff;
      rsp_read_data_in  = rsp_read_data_ff;
      rsp_read_valid_in = rsp_read_valid_ff;
      rsp_level_in      = rsp_level_ff;
      rsp_empty_in      = rsp_empty_ff;
      rsp_full_in       = rsp_full_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_valid_in      = 1'b1;
               rsp_accepted_in   = 1'b0;
               rsp_marker_in     = 1'b0;
               rsp_read_data_in  = '0;
               rsp_read_valid_in = 1'b0;
               case (req_op)
                  OP_PUSH: begin
                     if (cnt_ff < CNT_MARK_AT) begin
                        wr_en           = 1'b1;
                        wp_in           = ptr_next(wp_ff);
                        cnt_next        = cnt_ff + 1'b1;
                        rsp_accepted_in = 1'b1;
                     end else if (cnt_ff == CNT_MARK_AT) begin
                        wr_en         = 1'b1;
                        wr_data       = MARK_BYTES[0];
                        wp_in         = ptr_next(wp_ff);
                        cnt_next      = CNT_FULL;
                        mark_idx_in   = MARK_IDX_W'(1);
                        state_in      = ST_MARK;
                        rsp_marker_in = 1'b1;
                     end
                  end
                  OP_POP: begin
                     if (cnt_ff != '0) begin
                        rd_en        = 1'b1;
                        rp_in        = ptr_next(rp_ff);
                        cnt_next     = cnt_ff - 1'b1;
                        rsp_valid_in = 1'b0;
                        state_in     = ST_POP;
                     end
                  end
                  OP_CLEAR: begin
                     wp_in    = '0;
                     rp_in    = '0;
                     cnt_next = '0;
                  end
                  default: begin
                  end
               endcase
               cnt_in       = cnt_next;
               rsp_level_in = LEVEL_W'(cnt_next);
               rsp_empty_in = (cnt_next == '0);
               rsp_full_in  = (cnt_next == CNT_FULL);
            end
         end
         ST_POP: begin
            rsp_read_data_in  = rd_data;
            rsp_read_valid_in = 1'b1;
            rsp_valid_in      = 1'b1;
            state_in          = ST_IDLE;
         end
         ST_MARK: begin
            wr_en       = 1'b1;
            wr_data     = MARK_BYTES[mark_idx_ff];
            wp_in       = ptr_next(wp_ff);
            mark_idx_in = mark_idx_ff + 1'b1;
            if (mark_idx_ff == MARK_IDX_LAST) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         cnt_ff       <= '0;
         mark_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         cnt_ff       <= cnt_in;
         mark_idx_ff  <= mark_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_accepted_ff   <= rsp_accepted_in;
      rsp_marker_ff     <= rsp_marker_in;
      rsp_read_data_ff  <= rsp_read_data_in;
      rsp_read_valid_ff <= rsp_read_valid_in;
      rsp_level_ff      <= rsp_level_in;
      rsp_empty_ff      <= rsp_empty_in;
      rsp_full_ff       <= rsp_full_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = rsp_accepted_ff;
   assign rsp_marker_inserted = rsp_marker_ff;
   assign rsp_read_data       = rsp_read_data_ff;
   assign rsp_read_valid      = rsp_read_valid_ff;
   assign rsp_level           = rsp_level_ff;
   assign rsp_empty_res       = rsp_empty_ff;
   assign rsp_full_res        = rsp_full_ff;

   `BFOM_ASSERT_NEXT(a_pop_gives_word, clock, reset, state_ff == ST_POP, rsp_valid_ff && rsp_read_valid_ff)
   `BFOM_ASSERT_NEXT(a_marker_starts, clock, reset, state_ff == ST_IDLE && req_accept && req_op == OP_PUSH && cnt_ff == CNT_MARK_AT, state_ff == ST_MARK && cnt_ff == CNT_FULL)
   `BFOM_ASSERT_NEXT(a_marker_ends, clock, reset, state_ff == ST_MARK && mark_idx_ff == MARK_IDX_LAST, state_ff == ST_IDLE && wp_ff == rp_ff)
   `BFOM_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, cnt_ff <= CNT_FULL)

endmodule

### verif/byte_fifo_overflow_marker_tb.sv
// Self-checking testbench for the byte FIFO that writes an overflow marker when it fills.
`timescale 1ns / 100ps

module byte_fifo_overflow_marker_tb;
   import bfom_pkg::*;

   localparam logic [63:0] FULL_MARK_TEXT = "\r\nFULL\r\n";

   typedef struct packed {
      logic                 accepted;
      logic                 marker_inserted;
      logic [DATA_W-1:0]    read_data;
      logic                 read_valid;
      logic [LEVEL_W-1:0]   level;
      logic                 empty_res;
      logic                 full_res;
   } fifo_result_type;

   class fifo_scoreboard;
      logic [DATA_W-1:0] byte_store [DEPTH];
      logic [PTR_W-1:0]  wr_ptr;
      logic [PTR_W-1:0]  rd_ptr;
      logic [CNT_W-1:0]  fill;
      fifo_result_type   pending_results [$];
      int                mismatches;

      function new();
         wr_ptr = '0;
         rd_ptr = '0;
         fill = '0;
         mismatches = 0;
      endfunction

      function void store_byte(logic [DATA_W-1:0] b);
         byte_store[wr_ptr] = b;
         wr_ptr = PTR_W'((int'(wr_ptr) + 1) % DEPTH);
      endfunction

      function void note_request(op_type op, logic [DATA_W-1:0] data);
         fifo_result_type want;
         int room;
         want = '0;
         case (op)
            OP_PUSH: begin
               room = DEPTH - int'(fill);
               if (room > MARK_LEN) begin
                  store_byte(data);
                  fill = fill + 1'b1;
                  want.accepted = 1'b1;
               end else if (room == MARK_LEN) begin
                  for (int i = 0; i < MARK_LEN; i++) begin
                     store_byte(FULL_MARK_TEXT[63 - 8 * i -: 8]);
                  end
                  fill = fill + CNT_W'(MARK_LEN);
                  want.marker_inserted = 1'b1;
               end
            end
            OP_POP: begin
               if (fill != 0) begin
                  want.read_data = byte_store[rd_ptr];
                  want.read_valid = 1'b1;
                  rd_ptr = PTR_W'((int'(rd_ptr) + 1) % DEPTH);
                  fill = fill - 1'b1;
               end
            end
            OP_CLEAR: begin
               wr_ptr = '0;
               rd_ptr = '0;
               fill = '0;
            end
            default: begin
            end
         endcase
         want.level = LEVEL_W'(fill);
         want.empty_res = (fill == 0);
         want.full_res = (fill == CNT_W'(DEPTH));
         pending_results.push_back(want);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(fifo_result_type got);
         fifo_result_type want;
         if (pending_results.size() == 0) begin
            $error("Result word arrived with no request outstanding.");
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            compare_field("accepted", want.accepted, got.accepted);
            compare_field("marker_inserted", want.marker_inserted, got.marker_inserted);
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("read_valid", want.read_valid, got.read_valid);
            compare_field("level", want.level, got.level);
            compare_field("empty_res", want.empty_res, got.empty_res);
            compare_field("full_res", want.full_res, got.full_res);
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [1:0]          req_op;
   logic [DATA_W-1:0]   req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_accepted;
   logic                rsp_marker_inserted;
   logic [DATA_W-1:0]   rsp_read_data;
   logic                rsp_read_valid;
   logic [LEVEL_W-1:0]  rsp_level;
   logic                rsp_empty_res;
   logic                rsp_full_res;

   fifo_scoreboard sb;
   bit             burst_mode;
   int             words_taken;

   byte_fifo_overflow_marker i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_data            (req_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_accepted        (rsp_accepted),
      .rsp_marker_inserted (rsp_marker_inserted),
      .rsp_read_data       (rsp_read_data),
      .rsp_read_valid      (rsp_read_valid),
      .rsp_level           (rsp_level),
      .rsp_empty_res       (rsp_empty_res),
      .rsp_full_res        (rsp_full_res)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      #100ms;
      $display("** byte_fifo_overflow_marker: FAILED **");
      $finish;
   end

   task automatic send_request(input logic [1:0] op, input logic [DATA_W-1:0] data);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_data <= data;
      do @(posedge clock); while (req_stall);
      sb.note_request(op_type'(op), data);
   endtask

   task automatic send_random(output bit ignored);
      int pick;
      logic [1:0] op;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         op = OP_PUSH;
      end else if (pick < 88) begin
         op = OP_POP;
      end else if (pick < 93) begin
         op = OP_CLEAR;
      end else begin
         op = OP_NOP;
      end
      ignored = (op == OP_NOP);
      send_request(op, DATA_W'($urandom));
   endtask

   task automatic pop_bytes(input int count);
      repeat (count) send_request(OP_POP, DATA_W'($urandom));
   endtask

   task automatic push_bytes(input int count);
      repeat (count) send_request(OP_PUSH, DATA_W'($urandom));
   endtask

   initial begin
      int gap;
      fifo_result_type got;
      rsp_stall <= 1'b0;
      words_taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = burst_mode ? 0 : $urandom_range(0, 8);
         if (words_taken == 200) begin
            gap = 400;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         got.accepted = rsp_accepted;
         got.marker_inserted = rsp_marker_inserted;
         got.read_data = rsp_read_data;
         got.read_valid = rsp_read_valid;
         got.level = rsp_level;
         got.empty_res = rsp_empty_res;
         got.full_res = rsp_full_res;
         sb.check_result(got);
         words_taken++;
      end
   end

   initial begin
      int counted;
      int n;
      bit ignored;
      sb = new();
      burst_mode = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_op <= OP_NOP;
      req_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty pops, the unused code, byte extremes, and clears with and without data held.
      send_request(OP_POP, 8'h00);
      send_request(OP_NOP, 8'hFF);
      send_request(OP_PUSH, 8'h00);
      send_request(OP_PUSH, 8'hFF);
      send_request(OP_PUSH, 8'hA5);
      pop_bytes(4);
      send_request(OP_PUSH, 8'h5A);
      send_request(OP_PUSH, 8'h0F);
      send_request(OP_CLEAR, 8'h00);
      send_request(OP_POP, 8'h00);
      send_request(OP_PUSH, 8'hF0);
      send_request(OP_POP, 8'h00);
      send_request(OP_NOP, 8'h00);
      send_request(OP_CLEAR, 8'hFF);
      send_request(OP_PUSH, 8'h01);
      send_request(OP_PUSH, 8'h80);
      pop_bytes(2);

      counted = 0;
      n = 0;
      while (counted < 550) begin
         if (n % 50 == 0) begin
            burst_mode = ($urandom_range(0, 3) == 0);
         end
         send_random(ignored);
         if (!ignored) begin
            counted++;
         end
         n++;
      end
      burst_mode = 1'b0;
      push_bytes(40);

      // Fill from the current offset so the pointers wrap inside the store.
      n = 0;
      while (sb.fill != CNT_W'(DEPTH)) begin
         burst_mode = ((n / 512) % 4 != 3);
         send_request(OP_PUSH, DATA_W'($urandom));
         n++;
      end
      burst_mode = 1'b0;
      push_bytes(3);
      pop_bytes(5);
      push_bytes(2);
      pop_bytes(3);
      push_bytes(1);
      pop_bytes(9);
      push_bytes(2);
      send_request(OP_NOP, 8'h00);

      n = 0;
      while (sb.fill != 0) begin
         burst_mode = ((n / 512) % 4 != 1);
         if ($urandom_range(0, 19) == 0) begin
            send_request(OP_NOP, DATA_W'($urandom));
         end else begin
            send_request(OP_POP, DATA_W'($urandom));
         end
         n++;
      end
      burst_mode = 1'b0;
      pop_bytes(2);
      send_request(OP_CLEAR, 8'h00);
      for (n = 0; n < 60; n++) begin
         send_random(ignored);
      end
      req_valid <= 1'b0;

      for (n = 0; n < 10000 && sb.pending_results.size() != 0; n++) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (sb.pending_results.size() != 0) begin
         $error("%0d result words never arrived.", sb.pending_results.size());
         sb.mismatches++;
      end
      if (sb.mismatches == 0) begin
         $display("** byte_fifo_overflow_marker: PASSED **");
      end else begin
         $display("** byte_fifo_overflow_marker: FAILED **");
      end
      $finish;
   end

endmodule
